// ===== rtl/touch_uart_frame_parser_top_assert.svh =====
// Assertion macros for the touch UART frame parser.
`ifndef TOUCH_UART_FRAME_PARSER_TOP_ASSERT_SVH
`define TOUCH_UART_FRAME_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TUFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tufp assertion failed");
`define TUFP_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("tufp assertion failed");
`else
`define TUFP_ASSERT(label, clk, rst_n, prop)
`define TUFP_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== rtl/tufp_pkg.sv =====
package tufp_pkg;

  localparam int unsigned CNT_W      = 9;
  localparam int unsigned HDR_DEPTH  = 6;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [CNT_W-1:0] CNT_MAX       = 9'd511;
  localparam logic [CNT_W-1:0] MIN_FRAME     = 9'd4;
  localparam logic [CNT_W-1:0] REPORT_LEN    = 9'd6;
  localparam logic [CNT_W-1:0] RESP_OVERHEAD = 9'd3;
  localparam logic [7:0]       MIN_STATUS_LEN = 8'd2;

  localparam logic [7:0] HDR_REPORT  = 8'h01;
  localparam logic [7:0] HDR_RESP    = 8'h02;
  localparam logic [7:0] RESP_TAG    = 8'h4C;
  localparam logic [7:0] RESP_ADJUST = 8'h17;
  localparam logic [7:0] RESP_CALIB  = 8'h01;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] START_ADJUST = 2'd0;
  localparam logic [1:0] START_CALIB  = 2'd1;
  localparam logic [1:0] START_COORDS = 2'd2;

  localparam logic [0:0] REG_START_MODE = 1'b0;

  typedef enum logic [0:0] {
    KIND_TOUCH = 1'b0,
    KIND_CMD   = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    CMD_SETUP      = 3'd0,
    CMD_COORDS_ON  = 3'd1,
    CMD_COORDS_OFF = 3'd2,
    CMD_ADJUST     = 3'd3,
    CMD_CALIBRATE  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_ADJUST = 3'b001,
    MODE_CALIB  = 3'b010,
    MODE_COORDS = 3'b100
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic        touch_down;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    cmd_e        command;
    logic        last;
  } tufp_res_t;

  typedef struct packed {
    logic      vld0;
    logic      vld1;
    tufp_res_t res0;
    tufp_res_t res1;
  } tufp_push_t;

  function automatic tufp_res_t make_cmd(cmd_e cmd, logic last);
    tufp_res_t r;
    r.kind       = KIND_CMD;
    r.touch_down = 1'b0;
    r.x_pos      = 16'd0;
    r.y_pos      = 16'd0;
    r.command    = cmd;
    r.last       = last;
    return r;
  endfunction

endpackage

// ===== rtl/tufp_in_if.sv =====
interface tufp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== rtl/tufp_out_if.sv =====
interface tufp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        touch_down;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [2:0]  command;
  logic        last;

  modport source (
    output valid, output kind, output touch_down, output x_pos, output y_pos,
    output command, output last, input ready
  );
  modport sink (
    input valid, input kind, input touch_down, input x_pos, input y_pos,
    input command, input last, output ready
  );
endinterface

// ===== rtl/tufp_core.sv =====
module tufp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [1:0]          start_mode_i,
  input  logic                space_ok_i,
  output tufp_pkg::tufp_push_t push_o
);
  import tufp_pkg::*;

  logic                 in_vld_q;
  logic                 op_q;
  logic [7:0]           byte_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_inc, need;
  mode_e                mode_q, mode_d, start_mode;
  cmd_e                 start_cmd;
  logic [7:0]           hdr_q [HDR_DEPTH];
  logic [7:0]           hdr_v [HDR_DEPTH];
  logic                 proc, accept, is_resp, status_ok;
  tufp_res_t            touch_res;

  assign proc       = in_vld_q && space_ok_i;
  assign in_ready_o = !in_vld_q || space_ok_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      byte_q <= rx_byte_i;
    end
  end

  // overlay the new byte onto the stored header
  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hdr_v[i] = (cnt_q == CNT_W'(i)) ? byte_q : hdr_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && op_q == OP_BYTE) begin
      hdr_q <= hdr_v;
    end
  end

  assign cnt_inc   = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign need      = ({1'b0, hdr_v[2]} + RESP_OVERHEAD < MIN_FRAME) ? MIN_FRAME
                                                                   : {1'b0, hdr_v[2]} + RESP_OVERHEAD;
  assign is_resp   = hdr_v[0] == HDR_RESP && hdr_v[1] == RESP_TAG;
  assign status_ok = hdr_v[2] >= MIN_STATUS_LEN && hdr_v[4] != 8'd0;

  always_comb begin
    unique case (start_mode_i)
      START_ADJUST: begin
        start_mode = MODE_ADJUST;
        start_cmd  = CMD_ADJUST;
      end
      START_CALIB: begin
        start_mode = MODE_CALIB;
        start_cmd  = CMD_CALIBRATE;
      end
      default: begin
        start_mode = MODE_COORDS;
        start_cmd  = CMD_COORDS_ON;
      end
    endcase
  end

  always_comb begin
    touch_res.kind       = KIND_TOUCH;
    touch_res.touch_down = hdr_v[1] != 8'd0;
    touch_res.x_pos      = {hdr_v[3], hdr_v[2]};
    touch_res.y_pos      = {hdr_v[5], hdr_v[4]};
    touch_res.command    = CMD_SETUP;
    touch_res.last       = 1'b1;
  end

  always_comb begin
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    push_o.vld0 = 1'b0;
    push_o.vld1 = 1'b0;
    push_o.res0 = touch_res;
    push_o.res1 = make_cmd(CMD_COORDS_ON, 1'b1);
    if (proc) begin
      if (op_q == OP_START) begin
        cnt_d       = '0;
        mode_d      = start_mode;
        push_o.vld0 = 1'b1;
        push_o.vld1 = 1'b1;
        push_o.res0 = make_cmd(CMD_SETUP, 1'b0);
        push_o.res1 = make_cmd(start_cmd, 1'b1);
      end else if (cnt_inc < MIN_FRAME) begin
        cnt_d = cnt_inc;
      end else if (hdr_v[0] == HDR_REPORT) begin
        if (cnt_inc < REPORT_LEN) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d       = '0;
          push_o.vld0 = 1'b1;
        end
      end else if (is_resp) begin
        if (cnt_inc < need) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d = '0;
          if (hdr_v[3] == RESP_ADJUST && mode_q == MODE_ADJUST && status_ok) begin
            mode_d      = MODE_CALIB;
            push_o.vld0 = 1'b1;
            push_o.res0 = make_cmd(CMD_CALIBRATE, 1'b1);
          end else if (hdr_v[3] == RESP_CALIB && mode_q == MODE_CALIB && status_ok) begin
            mode_d      = MODE_COORDS;
            push_o.vld0 = 1'b1;
            push_o.res0 = make_cmd(CMD_COORDS_ON, 1'b1);
          end
        end
      end else begin
        // resync on an unknown header
        cnt_d       = '0;
        mode_d      = MODE_COORDS;
        push_o.vld0 = 1'b1;
        push_o.vld1 = 1'b1;
        push_o.res0 = make_cmd(CMD_COORDS_OFF, 1'b0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= MODE_COORDS;
    end else begin
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

endmodule

// ===== rtl/tufp_fifo.sv =====
`include "touch_uart_frame_parser_top_assert.svh"

module tufp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tufp_pkg::tufp_push_t push_i,
  output logic                 space_ok_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tufp_pkg::tufp_res_t  out_res_o
);
  import tufp_pkg::*;

  tufp_res_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, wr_ptr_nxt;
  logic [Q_CNT_W-1:0] count_q, count_d, push_n;
  logic               pop;

  assign space_ok_o  = count_q <= Q_CNT_W'(Q_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_nxt  = wr_ptr_q + 1'b1;
  assign push_n      = Q_CNT_W'(push_i.vld0) + Q_CNT_W'(push_i.vld1);
  assign wr_ptr_d    = wr_ptr_q + Q_PTR_W'(push_n);
  assign count_d     = count_q + push_n - Q_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  `TUFP_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > Q_CNT_W'(Q_DEPTH))
  `TUFP_ASSERT_NEVER(a_second_alone, clk_i, rst_ni, push_i.vld1 && !push_i.vld0)
  `TUFP_ASSERT(a_push_has_room, clk_i, rst_ni, push_i.vld0 |-> space_ok_o)
  `TUFP_ASSERT(a_idle_holds, clk_i, rst_ni, (!pop && !push_i.vld0) |=> $stable(count_q))

endmodule

// ===== rtl/touch_uart_frame_parser_top.sv =====
// A result beat is offered once its input beat has passed the input register and
// the result queue. Throughput: one input beat per cycle while the queue has room;
// results leave at one beat per cycle while out_if.ready is high, so a beat that
// yields two results can hold the input side. The four-entry result queue takes
// input only while at least two entries are free. Reset clears the frame count and
// queue, sets coordinate mode and start_mode to 2; stored frame bytes are not reset.
module touch_uart_frame_parser_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tufp_in_if.sink                          in_if,
  tufp_out_if.source                       out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tufp_pkg::PADDR_W-1:0]     paddr,
  input  logic [tufp_pkg::PDATA_W-1:0]     pwdata,
  output logic [tufp_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import tufp_pkg::*;

  logic [1:0] start_mode_q;
  logic       reg_hit;
  logic       space_ok;
  tufp_push_t push;
  tufp_res_t  out_res;

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1] == REG_START_MODE;
  assign prdata  = reg_hit ? PDATA_W'(start_mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mode_q <= START_COORDS;
    end else if (psel && penable && pwrite && reg_hit) begin
      start_mode_q <= pwdata[1:0];
    end
  end

  tufp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .operation_i  (in_if.operation),
    .rx_byte_i    (in_if.rx_byte),
    .start_mode_i (start_mode_q),
    .space_ok_i   (space_ok),
    .push_o       (push)
  );

  tufp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_res_o   (out_res)
  );

  assign out_if.kind       = out_res.kind;
  assign out_if.touch_down = out_res.touch_down;
  assign out_if.x_pos      = out_res.x_pos;
  assign out_if.y_pos      = out_res.y_pos;
  assign out_if.command    = out_res.command;
  assign out_if.last       = out_res.last;

endmodule
